[rtl/mqed_pkg.sv]
package mqed_pkg;

  localparam int unsigned NumEncodersDef = 16;
  localparam int unsigned EncIdxW        = 4;
  localparam int unsigned PairW          = 2;
  localparam int unsigned CountW         = 4;
  localparam int unsigned StepW          = 2;
  localparam int unsigned PpsW           = 4;
  localparam int unsigned PpsTableW      = 64;
  localparam int unsigned InvMaskW       = 16;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 64;

  localparam logic [PpsTableW-1:0] PpsTableRst   = 64'h4444_4444_4444_4444;
  localparam logic [InvMaskW-1:0]  InvMaskRst    = '0;
  localparam logic [CountW-1:0]    DefCountRst   = 4'd8;
  localparam logic [CountW-1:0]    ResetCount    = 4'd8;

  localparam logic [CfgIdxW-1:0] CfgPpsTable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvMask  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDefCount = 2'd2;

  localparam logic signed [StepW-1:0] StepNone = 2'sb00;
  localparam logic signed [StepW-1:0] StepPos  = 2'sb01;
  localparam logic signed [StepW-1:0] StepNeg  = 2'sb11;

  typedef struct packed {
    logic [PairW-1:0]  pair;
    logic [CountW-1:0] count;
    logic              dir;
  } enc_state_t;

  typedef struct packed {
    logic                    wr;
    enc_state_t              st;
    logic signed [StepW-1:0] step;
  } calc_res_t;

  localparam enc_state_t EncStateRst = '{pair: '0, count: ResetCount, dir: 1'b0};

  function automatic logic signed [StepW-1:0] trans_delta(input logic [3:0] idx);
    logic signed [StepW-1:0] d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = StepNeg;
      4'd2, 4'd4, 4'd11, 4'd13: d = StepPos;
      default: d = StepNone;
    endcase
    return d;
  endfunction

endpackage

[rtl/mqed_state_mem.sv]
module mqed_state_mem import mqed_pkg::*; #(
  parameter int unsigned NUM_ENCODERS = NumEncodersDef,
  parameter int unsigned AddrW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output enc_state_t       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  enc_state_t       wr_data_i
);

  enc_state_t              mem_q [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0] vld_q;
  enc_state_t              rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : EncStateRst;

endmodule

[rtl/mqed_step_logic.sv]
module mqed_step_logic import mqed_pkg::*; (
  input  enc_state_t        cur_i,
  input  logic [PairW-1:0]  pair_i,
  input  logic              in_range_i,
  input  logic [PpsW-1:0]   pps_i,
  input  logic              invert_i,
  input  logic [CountW-1:0] def_count_i,
  output calc_res_t         res_o
);

  logic signed [StepW-1:0] delta;
  logic                    dir;
  logic signed [5:0]       count_ext;
  logic [4:0]              mag;
  logic                    divisible;

  always_comb begin
    delta     = trans_delta({cur_i.pair, pair_i});
    dir       = (delta == StepPos);
    count_ext = $signed({2'b00, cur_i.count}) + 6'(delta);
    mag       = count_ext[5] ? 5'd1 : count_ext[4:0];
    divisible = 1'b0;
    for (int k = 0; k <= 16; k++) begin
      if (9'(mag) == 9'(k) * 9'(pps_i)) begin
        divisible = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.wr   = in_range_i;
    res_o.st   = cur_i;
    res_o.step = StepNone;
    res_o.st.pair = pair_i;
    if (delta != StepNone) begin
      res_o.st.count = count_ext[CountW-1:0];
      res_o.st.dir   = dir;
      if ((cur_i.dir == dir) && (pps_i != '0) && divisible) begin
        res_o.st.count = def_count_i;
        res_o.step     = (dir ^ invert_i) ? StepPos : StepNeg;
      end
    end
    if (!in_range_i) begin
      res_o.step = StepNone;
    end
  end

endmodule

[rtl/multi_quadrature_encoder_decoder_core.sv]
// Quadrature decoder for up to NUM_ENCODERS encoders sharing one sample channel.
// Each input item carries an encoder index and the sampled A/B pair of that
// encoder. The block answers every item with exactly one result item holding
// a step of +1, -1 or 0, in the order the items were taken.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The configuration port writes one register per cycle while
// cfg_we_i is high and should only be used while no item is in flight.
// An accepted item reads its encoder state into the registered read port of
// the state memory. In the StCalc state it is decoded and written back, and
// its step is loaded into the output register. No new item is taken while
// StCalc is active: the state memory read and write back form a loop.
// A result waits in the output register while out_stall_i is high; a new item
// is then held off until that result leaves, so nothing is lost.
// Reset clears the per-encoder valid flags, so every encoder reads as pair
// zero, count eight and negative direction without any clearing pass, and
// the configuration registers return to their reset values.
module multi_quadrature_encoder_decoder_core import mqed_pkg::*; #(
  parameter int unsigned NUM_ENCODERS = NumEncodersDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [EncIdxW-1:0]      encoder_index_i,
  input  logic [PairW-1:0]        pair_state_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [StepW-1:0] step_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCalc = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [PpsTableW-1:0]    pps_table_q;
  logic [InvMaskW-1:0]     inv_mask_q;
  logic [CountW-1:0]       def_count_q;
  logic [EncIdxW-1:0]      enc_q;
  logic [PairW-1:0]        pair_q;
  logic                    in_range_q;
  logic                    out_valid_q, out_valid_d;
  logic signed [StepW-1:0] step_q;
  logic                    in_accept;
  logic                    in_range;
  enc_state_t              rd_state;
  calc_res_t               res;
  logic                    calc;

  assign in_range   = (5'(encoder_index_i) < 5'(NUM_ENCODERS));
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign calc       = (state_q == StCalc);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StCalc;
        end
      end
      StCalc: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = calc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      pps_table_q <= PpsTableRst;
      inv_mask_q  <= InvMaskRst;
      def_count_q <= DefCountRst;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPpsTable: pps_table_q <= cfg_data_i[PpsTableW-1:0];
          CfgInvMask:  inv_mask_q  <= cfg_data_i[InvMaskW-1:0];
          CfgDefCount: def_count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      enc_q      <= encoder_index_i;
      pair_q     <= pair_state_i;
      in_range_q <= in_range;
    end
    if (calc) begin
      step_q <= res.step;
    end
  end

  mqed_state_mem #(
    .NUM_ENCODERS(NUM_ENCODERS),
    .AddrW       (AddrW)
  ) u_state_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept && in_range),
    .rd_addr_i(encoder_index_i[AddrW-1:0]),
    .rd_data_o(rd_state),
    .wr_en_i  (calc && res.wr),
    .wr_addr_i(enc_q[AddrW-1:0]),
    .wr_data_i(res.st)
  );

  mqed_step_logic u_step_logic (
    .cur_i      (rd_state),
    .pair_i     (pair_q),
    .in_range_i (in_range_q),
    .pps_i      (pps_table_q[{enc_q, 2'b00} +: PpsW]),
    .invert_i   (inv_mask_q[enc_q]),
    .def_count_i(def_count_q),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign step_o      = step_q;

  a_accept_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StCalc))
    else $error("accepted item did not enter the decode cycle");

  a_result_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == StCalc))
    else $error("result appeared without a decode cycle");

  a_out_free_for_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc |-> !(out_valid_q && out_stall_i))
    else $error("decode cycle would overwrite a waiting result");

  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (step_q == StepNone || step_q == StepPos || step_q == StepNeg))
    else $error("illegal step code on output");

endmodule

[test/multi_quadrature_encoder_decoder_core_tb.sv]
`timescale 1ns / 1ps

module multi_quadrature_encoder_decoder_core_tb;
  import mqed_pkg::*;

  localparam int unsigned NumPhases   = 8;
  localparam int unsigned RandPerPhase = 192;
  localparam int unsigned CycleLimit  = 300000;

  localparam int DeltaTab [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam logic [PairW-1:0] FwdNext [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [PairW-1:0] BwdNext [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  typedef struct packed {
    logic [EncIdxW-1:0] enc;
    logic [PairW-1:0]   pair;
  } sample_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [EncIdxW-1:0]      encoder_index_i = '0;
  logic [PairW-1:0]        pair_state_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [StepW-1:0] step_o;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;

  sample_t                 pending_samples[$];
  logic signed [StepW-1:0] expected_steps[$];
  sample_t                 next_sample;
  logic signed [StepW-1:0] oldest_step;
  bit                      gaps_on = 1'b1;
  int unsigned             mismatches = 0;
  int unsigned             cycle_count = 0;

  logic [PpsTableW-1:0]    cfg_pps = PpsTableRst;
  logic [InvMaskW-1:0]     cfg_invert = InvMaskRst;
  logic [CountW-1:0]       cfg_default = DefCountRst;
  logic [PairW-1:0]        enc_pair [16];
  logic [CountW-1:0]       enc_count [16];
  logic                    enc_dir [16];
  logic [PairW-1:0]        gen_pair [16];

  multi_quadrature_encoder_decoder_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .encoder_index_i,
    .pair_state_i,
    .out_valid_o,
    .out_stall_i,
    .step_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [StepW-1:0] predict_step(input logic [EncIdxW-1:0] enc,
                                                           input logic [PairW-1:0] pair);
    int                      delta;
    int                      cnt;
    int                      mag;
    logic                    dir;
    logic [PpsW-1:0]         pps;
    logic signed [StepW-1:0] res;
    res = StepNone;
    delta = DeltaTab[{enc_pair[enc], pair}];
    enc_pair[enc] = pair;
    if (delta != 0) begin
      dir = (delta > 0);
      cnt = int'(enc_count[enc]) + delta;
      enc_count[enc] = cnt[CountW-1:0];
      if (enc_dir[enc] != dir) begin
        enc_dir[enc] = dir;
      end else begin
        pps = cfg_pps[PpsW*enc +: PpsW];
        mag = (cnt < 0) ? -cnt : cnt;
        if (pps != 0 && (mag % int'(pps)) == 0) begin
          enc_count[enc] = cfg_default;
          res = (dir ^ cfg_invert[enc]) ? StepPos : StepNeg;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_steps.push_back(predict_step(encoder_index_i, pair_state_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 19)) begin
          next_sample = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          encoder_index_i <= next_sample.enc;
          pair_state_i <= next_sample.pair;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_steps.size() == 0) begin
          $error("step: expected none, actual %0d", step_o);
          mismatches++;
        end else begin
          oldest_step = expected_steps.pop_front();
          if (step_o !== oldest_step) begin
            $error("step: expected %0d, actual %0d", oldest_step, step_o);
            mismatches++;
          end
        end
      end
      out_stall_i <= gaps_on && ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgPpsTable: cfg_pps = val[PpsTableW-1:0];
      CfgInvMask:  cfg_invert = val[InvMaskW-1:0];
      CfgDefCount: cfg_default = val[CountW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_sample(input logic [EncIdxW-1:0] enc, input logic [PairW-1:0] pair);
    pending_samples.push_back('{enc: enc, pair: pair});
    gen_pair[enc] = pair;
  endtask

  task automatic add_spin(input logic [EncIdxW-1:0] enc, input bit fwd, input int n);
    for (int k = 0; k < n; k++) begin
      add_sample(enc, fwd ? FwdNext[gen_pair[enc]] : BwdNext[gen_pair[enc]]);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_steps.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [EncIdxW-1:0] enc;
    int unsigned        added;
    int unsigned        len;
    int unsigned        kind;
    for (int i = 0; i < 16; i++) begin
      enc_pair[i] = '0;
      enc_count[i] = ResetCount;
      enc_dir[i] = 1'b0;
      gen_pair[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: ;
        1: begin
          write_reg(CfgPpsTable, 64'h1111_1111_1111_1111);
          write_reg(CfgInvMask, 64'hFFFF);
          write_reg(CfgDefCount, 64'h0);
        end
        2: begin
          write_reg(CfgPpsTable, 64'h0);
          write_reg(CfgInvMask, 64'h0);
          write_reg(CfgDefCount, 64'hF);
        end
        3: begin
          write_reg(CfgPpsTable, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CfgInvMask, 64'hA5A5);
          write_reg(CfgDefCount, 64'h1);
        end
        4: begin
          write_reg(CfgPpsTable, 64'hFEDC_BA98_7654_3210);
          write_reg(CfgInvMask, 64'h00FF);
          write_reg(CfgDefCount, 64'h8);
        end
        default: begin
          write_reg(CfgPpsTable, {$urandom, $urandom});
          write_reg(CfgInvMask, CfgDataW'($urandom_range(0, 65535)));
          write_reg(CfgDefCount, CfgDataW'($urandom_range(0, 15)));
        end
      endcase
      gaps_on = (p != 1);

      if (p == 0) begin
        foreach (DeltaTab[k]) begin
          if (k < 9) add_sample(4'd0, (k == 0) ? 2'd0 : FwdNext[0]);
        end
        pending_samples.delete();
        gen_pair[0] = '0;
        add_sample(4'd0, 2'd0);
        add_sample(4'd0, 2'd1);
        add_sample(4'd0, 2'd3);
        add_sample(4'd0, 2'd2);
        add_sample(4'd0, 2'd0);
        add_sample(4'd0, 2'd2);
        add_sample(4'd0, 2'd0);
        add_sample(4'd0, 2'd1);
        add_sample(4'd15, 2'd2);
        add_sample(4'd15, 2'd3);
        add_sample(4'd15, 2'd1);
        add_sample(4'd15, 2'd0);
        add_sample(4'd15, 2'd2);
        add_sample(4'd15, 2'd3);
        add_sample(4'd15, 2'd1);
        add_sample(4'd15, 2'd0);
        add_sample(4'd15, 2'd3);
        add_sample(4'd5, 2'd3);
        add_sample(4'd5, 2'd0);
        add_sample(4'd5, 2'd1);
        add_sample(4'd10, 2'd2);
        add_sample(4'd10, 2'd2);
        add_sample(4'd10, 2'd1);
      end

      added = 0;
      while (added < RandPerPhase) begin
        enc = EncIdxW'($urandom_range(0, 15));
        kind = $urandom_range(0, 9);
        len = $urandom_range(1, 12);
        if (kind < 7) begin
          add_spin(enc, $urandom_range(0, 1), len);
        end else if (kind < 9) begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) add_sample(enc, PairW'($urandom_range(0, 3)));
        end else begin
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++) add_sample(enc, gen_pair[enc]);
        end
        added += len;
      end
      wait_drained();
    end

    gaps_on = 1'b0;
    repeat (10) @(posedge clk_i);
    if (expected_steps.size() != 0) begin
      $error("step: %0d results never arrived", expected_steps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mqed_pkg.sv
rtl/mqed_state_mem.sv
rtl/mqed_step_logic.sv
rtl/multi_quadrature_encoder_decoder_core.sv
test/multi_quadrature_encoder_decoder_core_tb.sv
